[sv/pph_pkg.sv]
package pph_pkg;

    // Command codes carried in s_axis_tuser.
    localparam logic [1:0] CMD_POINT = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_BOX_X_LOW  = 3'd0;
    localparam logic [2:0] CFG_BOX_X_HIGH = 3'd1;
    localparam logic [2:0] CFG_BOX_Y_LOW  = 3'd2;
    localparam logic [2:0] CFG_BOX_Y_HIGH = 3'd3;
    localparam logic [2:0] CFG_BOX_Z_LOW  = 3'd4;
    localparam logic [2:0] CFG_BOX_Z_HIGH = 3'd5;
    localparam logic [2:0] CFG_NORMAL     = 3'd6;
    localparam logic [2:0] CFG_OFFSET     = 3'd7;

    localparam int CMD_BITS       = 2;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 51;
    localparam int COORD_BITS     = 32;
    localparam int NORM_BITS      = 16;
    localparam int NORMAL_BITS    = 3 * NORM_BITS;
    localparam int OFFSET_BITS    = 51;
    localparam int PROD_BITS      = COORD_BITS + NORM_BITS;
    localparam int ACC_BITS       = 52;
    localparam int FRAC_DROP      = 14;
    localparam int DIST_FULL_BITS = ACC_BITS - FRAC_DROP;
    localparam int SEL_BITS       = 5;
    localparam int DIST_OUT_BITS  = 24;
    localparam int CNT_OUT_BITS   = 24;
    localparam int SUM_BITS       = 40;
    localparam int S_TDATA_BITS   = 104;
    localparam int M_TDATA_BITS   = 120;

    localparam int BIN_COUNT_DEF  = 30;
    localparam int BIN_WIDTH_DEF  = 655;
    localparam int COUNT_BITS_DEF = 24;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  x_low;
        logic signed [COORD_BITS-1:0]  x_high;
        logic signed [COORD_BITS-1:0]  y_low;
        logic signed [COORD_BITS-1:0]  y_high;
        logic signed [COORD_BITS-1:0]  z_low;
        logic signed [COORD_BITS-1:0]  z_high;
        logic [NORMAL_BITS-1:0]        normal;
        logic signed [OFFSET_BITS-1:0] offset;
    } t_cfg;

    // Control of one item as it leaves the front pipeline.
    typedef struct packed {
        logic                valid;
        logic [CMD_BITS-1:0] cmd;
        logic                in_box;
        logic                near;
        logic                hit;
    } t_ctl;

endpackage

[sv/pph_ram.sv]
module pph_ram #(
    parameter int  DEPTH     = 30,
    parameter int  DATA_BITS = 24,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0] o_rd_data,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0] i_wr_data
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/pph_front.sv]
module pph_front #(
    parameter int  BIN_COUNT = pph_pkg::BIN_COUNT_DEF,
    parameter int  BIN_WIDTH = pph_pkg::BIN_WIDTH_DEF,
    localparam int ADDR_BITS = $clog2(BIN_COUNT),
    localparam int NEAR_BITS = $clog2(BIN_COUNT * BIN_WIDTH)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [pph_pkg::CMD_BITS-1:0]          i_cmd,
    input  logic [pph_pkg::COORD_BITS-1:0]        i_x,
    input  logic [pph_pkg::COORD_BITS-1:0]        i_y,
    input  logic [pph_pkg::COORD_BITS-1:0]        i_z,
    input  logic [pph_pkg::SEL_BITS-1:0]          i_sel,
    input  pph_pkg::t_cfg                         i_cfg,
    output pph_pkg::t_ctl                         o_ctl,
    output logic [ADDR_BITS-1:0]                  o_addr,
    output logic [pph_pkg::SEL_BITS-1:0]          o_bin,
    output logic [pph_pkg::DIST_OUT_BITS-1:0]     o_dist,
    output logic [NEAR_BITS-1:0]                  o_near_dist
);

    localparam int LIMIT       = BIN_COUNT * BIN_WIDTH;
    localparam int RECIP       = (1 << NEAR_BITS) / BIN_WIDTH;
    localparam int RECIP_BITS  = NEAR_BITS + 1;
    localparam int MUL_BITS    = NEAR_BITS + RECIP_BITS;
    localparam int WIDTH_BITS  = $clog2(BIN_WIDTH + 1);
    localparam int QUOT_BITS   = ADDR_BITS + WIDTH_BITS;
    localparam int SELW_BITS   = ADDR_BITS + pph_pkg::SEL_BITS;
    localparam int CB          = pph_pkg::COORD_BITS;
    localparam int PB          = pph_pkg::PROD_BITS;
    localparam int AB          = pph_pkg::ACC_BITS;
    localparam int DB          = pph_pkg::DIST_FULL_BITS;
    localparam int OB          = pph_pkg::DIST_OUT_BITS;

    // Stage 1: captured beat.
    logic                          r_p1_valid;
    logic [pph_pkg::CMD_BITS-1:0]  r_p1_cmd;
    logic signed [CB-1:0]          r_p1_x;
    logic signed [CB-1:0]          r_p1_y;
    logic signed [CB-1:0]          r_p1_z;
    logic [pph_pkg::SEL_BITS-1:0]  r_p1_sel;

    // Stage 2: box test and the three products.
    logic                          r_p2_valid;
    logic [pph_pkg::CMD_BITS-1:0]  r_p2_cmd;
    logic [pph_pkg::SEL_BITS-1:0]  r_p2_sel;
    logic                          r_p2_in_box;
    logic signed [PB-1:0]          r_p2_prod_x;
    logic signed [PB-1:0]          r_p2_prod_y;
    logic signed [PB-1:0]          r_p2_prod_z;

    // Stage 3: signed distance with 30 fraction bits.
    logic                          r_p3_valid;
    logic [pph_pkg::CMD_BITS-1:0]  r_p3_cmd;
    logic [pph_pkg::SEL_BITS-1:0]  r_p3_sel;
    logic                          r_p3_in_box;
    logic signed [AB-1:0]          r_p3_acc;

    // Stage 4: Q8.16 magnitude, saturated, and the near test.
    logic                          r_p4_valid;
    logic [pph_pkg::CMD_BITS-1:0]  r_p4_cmd;
    logic [pph_pkg::SEL_BITS-1:0]  r_p4_sel;
    logic                          r_p4_in_box;
    logic                          r_p4_near;
    logic [OB-1:0]                 r_p4_dist;
    logic [NEAR_BITS-1:0]          r_p4_d;

    // Stage 5: reciprocal product for the bin number.
    logic                          r_p5_valid;
    logic [pph_pkg::CMD_BITS-1:0]  r_p5_cmd;
    logic [pph_pkg::SEL_BITS-1:0]  r_p5_sel;
    logic                          r_p5_in_box;
    logic                          r_p5_near;
    logic [OB-1:0]                 r_p5_dist;
    logic [NEAR_BITS-1:0]          r_p5_d;
    logic [MUL_BITS-1:0]           r_p5_prod;

    logic signed [CB-1:0]                  w_x_low, w_x_high, w_y_low, w_y_high;
    logic signed [CB-1:0]                  w_z_low, w_z_high;
    logic signed [pph_pkg::NORM_BITS-1:0]  w_nx, w_ny, w_nz;
    logic                                  w_in_box;
    logic signed [AB-1:0]                  w_acc;
    logic [AB-1:0]                         w_mag;
    logic [DB-1:0]                         w_dist;
    logic [OB-1:0]                         w_dist_sat;
    logic                                  w_near;
    logic [RECIP_BITS-1:0]                 w_q;
    logic [ADDR_BITS-1:0]                  w_qa;
    logic [QUOT_BITS-1:0]                  w_qw;
    logic [QUOT_BITS-1:0]                  w_rem;
    logic [ADDR_BITS-1:0]                  w_bin;
    logic [SELW_BITS-1:0]                  w_bin_w;
    logic [SELW_BITS-1:0]                  w_sel_w;
    logic                                  w_read_hit;
    logic                                  w_is_point;
    logic                                  w_is_read;

    assign w_x_low  = i_cfg.x_low;
    assign w_x_high = i_cfg.x_high;
    assign w_y_low  = i_cfg.y_low;
    assign w_y_high = i_cfg.y_high;
    assign w_z_low  = i_cfg.z_low;
    assign w_z_high = i_cfg.z_high;
    assign w_nx     = i_cfg.normal[pph_pkg::NORM_BITS-1:0];
    assign w_ny     = i_cfg.normal[2*pph_pkg::NORM_BITS-1:pph_pkg::NORM_BITS];
    assign w_nz     = i_cfg.normal[3*pph_pkg::NORM_BITS-1:2*pph_pkg::NORM_BITS];

    assign w_in_box = (r_p1_cmd == pph_pkg::CMD_POINT)
                      && (r_p1_x > w_x_low) && (r_p1_x < w_x_high)
                      && (r_p1_y > w_y_low) && (r_p1_y < w_y_high)
                      && (r_p1_z > w_z_low) && (r_p1_z < w_z_high);

    assign w_acc = AB'(r_p2_prod_x) + AB'(r_p2_prod_y) + AB'(r_p2_prod_z)
                   - AB'(i_cfg.offset);

    assign w_mag  = r_p3_acc[AB-1] ? AB'(-r_p3_acc) : AB'(r_p3_acc);
    assign w_dist = w_mag[AB-1:pph_pkg::FRAC_DROP];
    assign w_near = r_p3_in_box && (w_dist < DB'(LIMIT));

    always_comb begin
        if (!r_p3_in_box) begin
            w_dist_sat = '0;
        end else if (|w_dist[DB-1:OB]) begin
            w_dist_sat = '1;
        end else begin
            w_dist_sat = w_dist[OB-1:0];
        end
    end

    // The reciprocal quotient is exact or one low; one compare fixes it.
    assign w_q     = r_p5_prod[MUL_BITS-1:NEAR_BITS];
    assign w_qa    = w_q[ADDR_BITS-1:0];
    assign w_qw    = QUOT_BITS'(w_qa) * QUOT_BITS'(BIN_WIDTH);
    assign w_rem   = QUOT_BITS'(r_p5_d) - w_qw;
    assign w_bin   = (w_rem >= QUOT_BITS'(BIN_WIDTH)) ? w_qa + 1'b1 : w_qa;
    assign w_bin_w = {{pph_pkg::SEL_BITS{1'b0}}, w_bin};

    assign w_sel_w    = {{ADDR_BITS{1'b0}}, r_p5_sel};
    assign w_read_hit = w_sel_w < SELW_BITS'(BIN_COUNT);
    assign w_is_point = (r_p5_cmd == pph_pkg::CMD_POINT);
    assign w_is_read  = (r_p5_cmd == pph_pkg::CMD_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
            r_p5_valid <= 1'b0;
        end else if (i_en) begin
            r_p1_valid <= i_valid;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;
            r_p5_valid <= r_p4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_cmd    <= i_cmd;
            r_p1_x      <= i_x;
            r_p1_y      <= i_y;
            r_p1_z      <= i_z;
            r_p1_sel    <= i_sel;

            r_p2_cmd    <= r_p1_cmd;
            r_p2_sel    <= r_p1_sel;
            r_p2_in_box <= w_in_box;
            r_p2_prod_x <= r_p1_x * w_nx;
            r_p2_prod_y <= r_p1_y * w_ny;
            r_p2_prod_z <= r_p1_z * w_nz;

            r_p3_cmd    <= r_p2_cmd;
            r_p3_sel    <= r_p2_sel;
            r_p3_in_box <= r_p2_in_box;
            r_p3_acc    <= w_acc;

            r_p4_cmd    <= r_p3_cmd;
            r_p4_sel    <= r_p3_sel;
            r_p4_in_box <= r_p3_in_box;
            r_p4_near   <= w_near;
            r_p4_dist   <= w_dist_sat;
            r_p4_d      <= w_dist[NEAR_BITS-1:0];

            r_p5_cmd    <= r_p4_cmd;
            r_p5_sel    <= r_p4_sel;
            r_p5_in_box <= r_p4_in_box;
            r_p5_near   <= r_p4_near;
            r_p5_dist   <= r_p4_dist;
            r_p5_d      <= r_p4_d;
            r_p5_prod   <= MUL_BITS'(r_p4_d) * MUL_BITS'(RECIP);
        end
    end

    always_comb begin
        o_ctl.valid  = r_p5_valid;
        o_ctl.cmd    = r_p5_cmd;
        o_ctl.in_box = r_p5_in_box;
        o_ctl.near   = r_p5_near;
        o_ctl.hit    = w_is_point ? r_p5_near : (w_is_read && w_read_hit);
        o_addr       = w_is_point ? w_bin : w_sel_w[ADDR_BITS-1:0];
        if (w_is_point && r_p5_near) begin
            o_bin = w_bin_w[pph_pkg::SEL_BITS-1:0];
        end else if (w_is_read) begin
            o_bin = r_p5_sel;
        end else begin
            o_bin = '0;
        end
    end

    assign o_dist      = r_p5_dist;
    assign o_near_dist = r_p5_d;

endmodule

[sv/pph_update.sv]
module pph_update #(
    parameter int  BIN_COUNT  = pph_pkg::BIN_COUNT_DEF,
    parameter int  BIN_WIDTH  = pph_pkg::BIN_WIDTH_DEF,
    parameter int  COUNT_BITS = pph_pkg::COUNT_BITS_DEF,
    localparam int ADDR_BITS  = $clog2(BIN_COUNT),
    localparam int NEAR_BITS  = $clog2(BIN_COUNT * BIN_WIDTH)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  pph_pkg::t_ctl                        i_ctl,
    input  logic [ADDR_BITS-1:0]                 i_addr,
    input  logic [pph_pkg::SEL_BITS-1:0]         i_bin,
    input  logic [pph_pkg::DIST_OUT_BITS-1:0]    i_dist,
    input  logic [NEAR_BITS-1:0]                 i_near_dist,
    output logic                                 o_valid,
    output logic [pph_pkg::M_TDATA_BITS-1:0]     o_data
);

    localparam int SB = pph_pkg::SUM_BITS;
    localparam int CO = pph_pkg::CNT_OUT_BITS;

    pph_pkg::t_ctl                       r_u_ctl;
    logic [ADDR_BITS-1:0]                r_u_addr;
    logic [pph_pkg::SEL_BITS-1:0]        r_u_bin;
    logic [pph_pkg::DIST_OUT_BITS-1:0]   r_u_dist;
    logic [NEAR_BITS-1:0]                r_u_d;

    logic [BIN_COUNT-1:0]                r_hvalid;
    logic                                r_lw_valid;
    logic [ADDR_BITS-1:0]                r_lw_addr;
    logic [COUNT_BITS-1:0]               r_lw_data;
    logic [COUNT_BITS-1:0]               r_near;
    logic [SB-1:0]                       r_sum;

    logic [COUNT_BITS-1:0]               n_near;
    logic [SB-1:0]                       n_sum;

    logic [COUNT_BITS-1:0]               w_rd_data;
    logic                                w_fwd;
    logic [COUNT_BITS-1:0]               w_old;
    logic [COUNT_BITS-1:0]               w_cnt_inc;
    logic                                w_upd;
    logic                                w_clr;
    logic [SB:0]                         w_sum_add;
    logic [COUNT_BITS-1:0]               w_bin_count;
    logic [COUNT_BITS+CO-1:0]            w_cnt_ext;
    logic [COUNT_BITS+CO-1:0]            w_near_ext;

    // The bin is read while the item sits one stage earlier; data arrives here.
    pph_ram #(
        .DEPTH     (BIN_COUNT),
        .DATA_BITS (COUNT_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_en      (i_en),
        .i_rd_addr (i_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (i_en && w_upd),
        .i_wr_addr (r_u_addr),
        .i_wr_data (w_cnt_inc)
    );

    // The write of the previous item lands on the same edge as this item's
    // read, so the RAM returns the old count; take the forwarded one instead.
    // Bins not written since the last clear read as zero.
    assign w_fwd = r_lw_valid && (r_lw_addr == r_u_addr);
    assign w_old = w_fwd ? r_lw_data : (r_hvalid[r_u_addr] ? w_rd_data : '0);

    assign w_upd     = r_u_ctl.valid && (r_u_ctl.cmd == pph_pkg::CMD_POINT) && r_u_ctl.near;
    assign w_clr     = r_u_ctl.valid && (r_u_ctl.cmd == pph_pkg::CMD_CLEAR);
    assign w_cnt_inc = (&w_old) ? w_old : w_old + 1'b1;
    assign w_sum_add = {1'b0, r_sum} + (SB + 1)'(r_u_d);

    always_comb begin
        if (w_clr) begin
            n_near = '0;
            n_sum  = '0;
        end else if (w_upd) begin
            n_near = (&r_near) ? r_near : r_near + 1'b1;
            n_sum  = w_sum_add[SB] ? '1 : w_sum_add[SB-1:0];
        end else begin
            n_near = r_near;
            n_sum  = r_sum;
        end
    end

    always_comb begin
        if (w_upd) begin
            w_bin_count = w_cnt_inc;
        end else if ((r_u_ctl.cmd == pph_pkg::CMD_READ) && r_u_ctl.hit) begin
            w_bin_count = w_old;
        end else begin
            w_bin_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_ctl    <= '0;
            r_hvalid   <= '0;
            r_lw_valid <= 1'b0;
            r_near     <= '0;
            r_sum      <= '0;
        end else if (i_en) begin
            r_u_ctl    <= i_ctl;
            r_lw_valid <= w_upd;
            r_near     <= n_near;
            r_sum      <= n_sum;
            if (w_clr) begin
                r_hvalid <= '0;
            end else if (w_upd) begin
                r_hvalid[r_u_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u_addr  <= i_addr;
            r_u_bin   <= i_bin;
            r_u_dist  <= i_dist;
            r_u_d     <= i_near_dist;
            r_lw_addr <= r_u_addr;
            r_lw_data <= w_cnt_inc;
        end
    end

    assign w_cnt_ext  = {{CO{1'b0}}, w_bin_count};
    assign w_near_ext = {{CO{1'b0}}, n_near};

    assign o_valid = r_u_ctl.valid;
    assign o_data  = {1'b0, n_sum, w_near_ext[CO-1:0], w_cnt_ext[CO-1:0], r_u_bin,
                      r_u_dist, r_u_ctl.near, r_u_ctl.in_box};

endmodule

[sv/point_plane_distance_histogram.sv]
// Point-to-plane distance histogram.
//
// Input beats on s_axis carry one command each: a point sample, a read of one
// histogram bin, or a clear of all statistics (tuser). Every beat gives
// exactly one output beat on m_axis, in order. Software sets the box bounds,
// the packed unit normal and the plane offset through the write port while no
// beat is in flight.
//
// Throughput is one beat per cycle while the skid register is empty. A beat
// accepted on s_axis passes the input register, the arithmetic stages (box
// test and products, dot sum, magnitude, reciprocal multiply for the bin
// number), the bin RAM read, and the count update and output register. The
// histogram is a single-port-write RAM read one stage ahead of its update;
// back-to-back hits on the same bin use a forwarded count.
//
// Reset clears the configuration, empties the pipeline and marks every bin
// empty through per-bin valid bits, so no sweep of the RAM is needed. When
// the receiver stalls, the output register holds its beat and one more beat
// goes into a skid register; with the skid full, s_axis_tready drops and the
// whole pipeline holds.
module point_plane_distance_histogram #(
    parameter int BIN_COUNT  = pph_pkg::BIN_COUNT_DEF,
    parameter int BIN_WIDTH  = pph_pkg::BIN_WIDTH_DEF,
    parameter int COUNT_BITS = pph_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // point_x[31:0], point_y[63:32], point_z[95:64], bin_select[100:96]
    input  logic [pph_pkg::S_TDATA_BITS-1:0]    s_axis_tdata,
    // cmd[1:0]
    input  logic [pph_pkg::CMD_BITS-1:0]        s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // in_box[0], near_plane[1], distance[25:2], bin_index[30:26],
    // bin_count[54:31], near_total[78:55], distance_sum[118:79]
    output logic [pph_pkg::M_TDATA_BITS-1:0]    m_axis_tdata,

    input  logic                                i_cfg_we,
    input  logic [pph_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [pph_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int ADDR_BITS = $clog2(BIN_COUNT);
    localparam int NEAR_BITS = $clog2(BIN_COUNT * BIN_WIDTH);
    localparam int LIMIT     = BIN_COUNT * BIN_WIDTH;
    localparam int CB        = pph_pkg::COORD_BITS;
    localparam int MB        = pph_pkg::M_TDATA_BITS;

    logic [CB-1:0]                    r_box_x_low, r_box_x_high;
    logic [CB-1:0]                    r_box_y_low, r_box_y_high;
    logic [CB-1:0]                    r_box_z_low, r_box_z_high;
    logic [pph_pkg::NORMAL_BITS-1:0]  r_normal;
    logic [pph_pkg::OFFSET_BITS-1:0]  r_offset;

    logic                             r_out_valid;
    logic [MB-1:0]                    r_out_data;
    logic                             r_skid_valid;
    logic [MB-1:0]                    r_skid_data;

    pph_pkg::t_cfg                    w_cfg;
    pph_pkg::t_ctl                    w_ctl;
    logic                             w_en;
    logic [ADDR_BITS-1:0]             w_addr;
    logic [pph_pkg::SEL_BITS-1:0]     w_bin;
    logic [pph_pkg::DIST_OUT_BITS-1:0] w_dist;
    logic [NEAR_BITS-1:0]             w_near_dist;
    logic                             w_res_valid;
    logic [MB-1:0]                    w_res_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_x_low  <= '0;
            r_box_x_high <= '0;
            r_box_y_low  <= '0;
            r_box_y_high <= '0;
            r_box_z_low  <= '0;
            r_box_z_high <= '0;
            r_normal     <= '0;
            r_offset     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pph_pkg::CFG_BOX_X_LOW: begin
                    r_box_x_low <= i_cfg_data[CB-1:0];
                end
                pph_pkg::CFG_BOX_X_HIGH: begin
                    r_box_x_high <= i_cfg_data[CB-1:0];
                end
                pph_pkg::CFG_BOX_Y_LOW: begin
                    r_box_y_low <= i_cfg_data[CB-1:0];
                end
                pph_pkg::CFG_BOX_Y_HIGH: begin
                    r_box_y_high <= i_cfg_data[CB-1:0];
                end
                pph_pkg::CFG_BOX_Z_LOW: begin
                    r_box_z_low <= i_cfg_data[CB-1:0];
                end
                pph_pkg::CFG_BOX_Z_HIGH: begin
                    r_box_z_high <= i_cfg_data[CB-1:0];
                end
                pph_pkg::CFG_NORMAL: begin
                    r_normal <= i_cfg_data[pph_pkg::NORMAL_BITS-1:0];
                end
                pph_pkg::CFG_OFFSET: begin
                    r_offset <= i_cfg_data[pph_pkg::OFFSET_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_cfg.x_low  = r_box_x_low;
        w_cfg.x_high = r_box_x_high;
        w_cfg.y_low  = r_box_y_low;
        w_cfg.y_high = r_box_y_high;
        w_cfg.z_low  = r_box_z_low;
        w_cfg.z_high = r_box_z_high;
        w_cfg.normal = r_normal;
        w_cfg.offset = r_offset;
    end

    // The pipeline moves whenever the skid register is free.
    assign w_en          = !r_skid_valid;
    assign s_axis_tready = w_en;

    pph_front #(
        .BIN_COUNT (BIN_COUNT),
        .BIN_WIDTH (BIN_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (s_axis_tvalid),
        .i_cmd       (s_axis_tuser),
        .i_x         (s_axis_tdata[CB-1:0]),
        .i_y         (s_axis_tdata[2*CB-1:CB]),
        .i_z         (s_axis_tdata[3*CB-1:2*CB]),
        .i_sel       (s_axis_tdata[3*CB+pph_pkg::SEL_BITS-1:3*CB]),
        .i_cfg       (w_cfg),
        .o_ctl       (w_ctl),
        .o_addr      (w_addr),
        .o_bin       (w_bin),
        .o_dist      (w_dist),
        .o_near_dist (w_near_dist)
    );

    pph_update #(
        .BIN_COUNT  (BIN_COUNT),
        .BIN_WIDTH  (BIN_WIDTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_ctl       (w_ctl),
        .i_addr      (w_addr),
        .i_bin       (w_bin),
        .i_dist      (w_dist),
        .i_near_dist (w_near_dist),
        .o_valid     (w_res_valid),
        .o_data      (w_res_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= w_res_valid;
        end else if (w_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out_data <= r_skid_data;
            end
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_data <= w_res_data;
        end else begin
            r_skid_data <= w_res_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a beat while the output register is empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !m_axis_tready |=> r_skid_valid && $stable(r_skid_data))
        else $error("skid beat lost or changed while the receiver stalls");

    a_near_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |->
            m_axis_tdata[0] && (32'(m_axis_tdata[25:2]) < LIMIT)
            && (32'(m_axis_tdata[30:26]) < BIN_COUNT))
        else $error("near beat with point outside box or bin out of range");

endmodule
